@@ hw/rtl/cac_pkg.sv @@
`default_nettype none
package cac_pkg;

  // Assignment store geometry
  localparam int unsigned MAX_VARS   = 1024;
  localparam int unsigned ADDR_W     = $clog2(MAX_VARS);
  localparam int unsigned CNT_W      = 11;
  localparam logic [CNT_W-1:0] NONE_BAD = '1;

  // Front-to-back queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // Stream widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    ACT_ASSIGN  = 2'd0,
    ACT_CLAUSE  = 2'd1,
    ACT_LITERAL = 2'd2,
    ACT_END     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_VARIABLE_TOTAL = 2'd0,
    CFG_WORK_LIMIT     = 2'd1,
    CFG_WORK_START     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    V_OK        = 3'd0,
    V_REJECT    = 3'd1,
    V_BUDGET    = 3'd2,
    V_SAFE      = 3'd3,
    V_UNDECIDED = 3'd4
  } verdict_e;

  typedef enum logic {
    PH_LOAD   = 1'b0,
    PH_CLAUSE = 1'b1
  } phase_e;

  // Request class as seen by the back end
  typedef enum logic [2:0] {
    K_LOAD       = 3'd0,
    K_MIS_ASSIGN = 3'd1,
    K_MIS_LIT    = 3'd2,
    K_CLAUSE     = 3'd3,
    K_LITERAL    = 3'd4,
    K_END        = 3'd5
  } kind_e;

  typedef struct packed {
    logic [CNT_W-1:0] variable_total;
    logic [31:0]      work_limit;
    logic [31:0]      work_start;
  } cfg_t;

  // Front stage register (waits on the RAM read)
  typedef struct packed {
    kind_e       kind;
    logic        endload;
    verdict_e    el_verdict;
    logic [31:0] el_off;
    logic        lit_bad;
    logic        lit_neg;
  } s1_t;

  // Queue entry
  typedef struct packed {
    kind_e       kind;
    logic        endload;
    verdict_e    el_verdict;
    logic [31:0] el_work;
    logic        lit_bad;
    logic        lit_true;
  } entry_t;

endpackage
`default_nettype wire

@@ hw/rtl/cac_ram.sv @@
`default_nettype none
module cac_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire                     re_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cac_front.sv @@
`default_nettype none
module cac_front (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire cac_pkg::cfg_t         cfg_i,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire [1:0]                  in_action_i,
  input  wire [7:0]                  in_assign_i,
  input  wire [31:0]                 in_literal_i,
  output logic                       push_o,
  output cac_pkg::entry_t            entry_o,
  input  wire                        full_i
);

  logic                         accept;
  cac_pkg::action_e             action;
  cac_pkg::phase_e              phase_q, phase_d;
  logic [cac_pkg::CNT_W-1:0]    loaded_q, loaded_d;
  logic [cac_pkg::CNT_W-1:0]    first_bad_q, first_bad_d;
  logic                         s1_valid_q, s1_valid_d;
  cac_pkg::s1_t                 s1_q, s1_d;
  logic                         lit_neg;
  logic [31:0]                  mag;
  logic [31:0]                  mag_m1;
  logic [31:0]                  avail;
  logic                         short_load;
  logic                         ram_we, ram_re;
  logic                         ram_rdata;

  assign action     = cac_pkg::action_e'(in_action_i);
  assign in_ready_o = !s1_valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = s1_valid_q && !full_i;

  // Literal decode
  assign lit_neg = in_literal_i[31];
  assign mag     = lit_neg ? (~in_literal_i + 32'd1) : in_literal_i;
  assign mag_m1  = mag - 32'd1;

  // Assignment bit store
  assign ram_we = accept && (action == cac_pkg::ACT_ASSIGN) && (phase_q == cac_pkg::PH_LOAD)
                  && (loaded_q < cac_pkg::CNT_W'(cac_pkg::MAX_VARS));
  assign ram_re = accept && (action == cac_pkg::ACT_LITERAL);

  cac_ram #(
    .WIDTH (1),
    .DEPTH (cac_pkg::MAX_VARS)
  ) u_bits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (loaded_q[cac_pkg::ADDR_W-1:0]),
    .wdata_i (in_assign_i[0]),
    .re_i    (ram_re),
    .raddr_i (mag_m1[cac_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // End-of-load outcome, from counts and config only
  assign avail = (cfg_i.work_limit >= cfg_i.work_start) ?
                 (cfg_i.work_limit - cfg_i.work_start) : 32'd0;
  assign short_load = (loaded_q < cfg_i.variable_total) ||
                      (cfg_i.variable_total > cac_pkg::CNT_W'(cac_pkg::MAX_VARS));

  always_comb begin
    s1_d = s1_q;
    s1_d.endload    = (phase_q == cac_pkg::PH_LOAD);
    s1_d.lit_neg    = lit_neg;
    s1_d.lit_bad    = (in_literal_i == 32'd0) || (in_literal_i == 32'h8000_0000) ||
                      (mag > {21'd0, cfg_i.variable_total}) ||
                      (mag > 32'(cac_pkg::MAX_VARS));
    if (short_load) begin
      s1_d.el_verdict = cac_pkg::V_SAFE;
      s1_d.el_off     = 32'd0;
    end else if ((first_bad_q < cfg_i.variable_total) && ({21'd0, first_bad_q} < avail)) begin
      s1_d.el_verdict = cac_pkg::V_SAFE;
      s1_d.el_off     = {21'd0, first_bad_q} + 32'd1;
    end else if ({21'd0, cfg_i.variable_total} > avail) begin
      s1_d.el_verdict = cac_pkg::V_BUDGET;
      s1_d.el_off     = avail;
    end else begin
      s1_d.el_verdict = cac_pkg::V_UNDECIDED;
      s1_d.el_off     = {21'd0, cfg_i.variable_total};
    end
    case (action)
      cac_pkg::ACT_ASSIGN:  s1_d.kind = (phase_q == cac_pkg::PH_LOAD) ?
                                        cac_pkg::K_LOAD : cac_pkg::K_MIS_ASSIGN;
      cac_pkg::ACT_CLAUSE:  s1_d.kind = cac_pkg::K_CLAUSE;
      cac_pkg::ACT_LITERAL: s1_d.kind = (phase_q == cac_pkg::PH_LOAD) ?
                                        cac_pkg::K_MIS_LIT : cac_pkg::K_LITERAL;
      default:              s1_d.kind = cac_pkg::K_END;
    endcase
  end

  // Load-phase tracking
  always_comb begin
    phase_d     = phase_q;
    loaded_d    = loaded_q;
    first_bad_d = first_bad_q;
    if (accept) begin
      case (action)
        cac_pkg::ACT_ASSIGN: begin
          if (phase_q == cac_pkg::PH_LOAD) begin
            if ((in_assign_i > 8'd1) && (first_bad_q == cac_pkg::NONE_BAD) &&
                (loaded_q != cac_pkg::NONE_BAD)) begin
              first_bad_d = loaded_q;
            end
            if (loaded_q != cac_pkg::NONE_BAD) begin
              loaded_d = loaded_q + cac_pkg::CNT_W'(1);
            end
          end
        end
        cac_pkg::ACT_CLAUSE: phase_d = cac_pkg::PH_CLAUSE;
        cac_pkg::ACT_END: begin
          phase_d     = cac_pkg::PH_LOAD;
          loaded_d    = '0;
          first_bad_d = cac_pkg::NONE_BAD;
        end
        default: ;
      endcase
    end
  end

  assign s1_valid_d = accept ? 1'b1 : (push_o ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= cac_pkg::PH_LOAD;
      loaded_q    <= '0;
      first_bad_q <= cac_pkg::NONE_BAD;
      s1_valid_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      loaded_q    <= loaded_d;
      first_bad_q <= first_bad_d;
      s1_valid_q  <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  // RAM data holds while the stage stalls, since no new read is issued
  always_comb begin
    entry_o.kind       = s1_q.kind;
    entry_o.endload    = s1_q.endload;
    entry_o.el_verdict = s1_q.el_verdict;
    entry_o.el_work    = cfg_i.work_start + s1_q.el_off;
    entry_o.lit_bad    = s1_q.lit_bad;
    entry_o.lit_true   = ram_rdata ^ s1_q.lit_neg;
  end

endmodule
`default_nettype wire

@@ hw/rtl/cac_fifo.sv @@
`default_nettype none
module cac_fifo (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire cac_pkg::entry_t entry_i,
  output logic             full_o,
  input  wire              pop_i,
  output cac_pkg::entry_t  entry_o,
  output logic             empty_o
);

  cac_pkg::entry_t                 slot_q [cac_pkg::FIFO_DEPTH];
  logic [cac_pkg::FIFO_PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [cac_pkg::FIFO_PTR_W:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == (cac_pkg::FIFO_PTR_W+1)'(cac_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == cac_pkg::FIFO_PTR_W'(cac_pkg::FIFO_DEPTH - 1)) ? '0 :
             wr_q + cac_pkg::FIFO_PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == cac_pkg::FIFO_PTR_W'(cac_pkg::FIFO_DEPTH - 1)) ? '0 :
             rd_q + cac_pkg::FIFO_PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + (cac_pkg::FIFO_PTR_W+1)'(1);
      2'b01:   cnt_d = cnt_q - (cac_pkg::FIFO_PTR_W+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cac_back.sv @@
`default_nettype none
module cac_back (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire cac_pkg::cfg_t              cfg_i,
  input  wire cac_pkg::entry_t            entry_i,
  input  wire                             empty_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [cac_pkg::OUT_DATA_W-1:0]  out_data_o
);

  cac_pkg::verdict_e verdict_q, verdict_d;
  logic [31:0]       work_q, work_d;
  logic              open_q, open_d;
  logic              sat_q, sat_d;
  logic [31:0]       ct_q, ct_d;
  logic [31:0]       lt_q, lt_d;
  logic              out_valid_q, out_valid_d;
  logic [cac_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic              is_end;

  assign is_end = (entry_i.kind == cac_pkg::K_END);
  assign pop_o  = !empty_i && (!is_end || !out_valid_q || out_ready_i);

  always_comb begin
    cac_pkg::verdict_e v;
    logic [31:0]       w;
    logic              op;
    logic              st;
    logic [32:0]       units;
    v  = verdict_q;
    w  = work_q;
    op = open_q;
    st = sat_q;
    units = '0;
    ct_d  = ct_q;
    lt_d  = lt_q;
    out_data_d  = out_data_q;
    out_valid_d = (out_valid_q && !out_ready_i);
    if (pop_o) begin
      if (entry_i.kind == cac_pkg::K_CLAUSE || entry_i.kind == cac_pkg::K_END) begin
        if (entry_i.endload && v == cac_pkg::V_UNDECIDED) begin
          v = entry_i.el_verdict;
          w = entry_i.el_work;
        end
        if (op && !st && v == cac_pkg::V_UNDECIDED) begin
          v = cac_pkg::V_REJECT;
        end
        op = 1'b0;
        st = 1'b0;
      end
      case (entry_i.kind)
        cac_pkg::K_LOAD: ;
        cac_pkg::K_MIS_ASSIGN: begin
          if (v == cac_pkg::V_UNDECIDED) v = cac_pkg::V_SAFE;
        end
        cac_pkg::K_MIS_LIT: begin
          if (lt_q != '1) lt_d = lt_q + 32'd1;
          if (v == cac_pkg::V_UNDECIDED) v = cac_pkg::V_SAFE;
        end
        cac_pkg::K_CLAUSE: begin
          if (ct_q != '1) ct_d = ct_q + 32'd1;
          if (v == cac_pkg::V_UNDECIDED) begin
            if (w < cfg_i.work_limit) begin
              w  = w + 32'd1;
              op = 1'b1;
            end else begin
              v = cac_pkg::V_BUDGET;
            end
          end
        end
        cac_pkg::K_LITERAL: begin
          if (lt_q != '1) lt_d = lt_q + 32'd1;
          if (v == cac_pkg::V_UNDECIDED) begin
            if (!op) begin
              v = cac_pkg::V_SAFE;
            end else if (!st) begin
              if (w < cfg_i.work_limit) begin
                w = w + 32'd1;
                if (entry_i.lit_bad) begin
                  v = cac_pkg::V_SAFE;
                end else if (entry_i.lit_true) begin
                  st = 1'b1;
                end
              end else begin
                v = cac_pkg::V_BUDGET;
              end
            end
          end
        end
        cac_pkg::K_END: begin
          if (v == cac_pkg::V_UNDECIDED) v = cac_pkg::V_OK;
          units = {1'b0, ct_q} + {1'b0, lt_q} + 33'd1;
          out_data_d  = {5'd0, units, w, v[1:0]};
          out_valid_d = 1'b1;
          // Fresh formula
          v    = cac_pkg::V_UNDECIDED;
          w    = '0;
          op   = 1'b0;
          st   = 1'b0;
          ct_d = '0;
          lt_d = '0;
        end
        default: ;
      endcase
    end
    verdict_d = v;
    work_d    = w;
    open_d    = op;
    sat_d     = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verdict_q   <= cac_pkg::V_UNDECIDED;
      work_q      <= '0;
      open_q      <= 1'b0;
      sat_q       <= 1'b0;
      ct_q        <= '0;
      lt_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      verdict_q   <= verdict_d;
      work_q      <= work_d;
      open_q      <= open_d;
      sat_q       <= sat_d;
      ct_q        <= ct_d;
      lt_q        <= lt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

@@ hw/rtl/cnf_assignment_checker_unit.sv @@
// Channel   | Dir | Signals                         | Content
// s_axis    | in  | tvalid tready tdata[39:0] tuser | one formula request per handshake
// m_axis    | out | tvalid tready tdata[71:0]       | one verdict per end request
// cfg       | in  | cfg_we_i cfg_idx_i cfg_wdata_i  | register write, no read-back
//
// Throughput is one request per cycle unless the queue is full or a verdict
// is stalled; set by the back end's work-count update, which handles one
// queued request each cycle. A request passes the front stage with the
// assignment RAM read, the queue and the output register to its verdict.
// Reset is asynchronous, active low; no clearing pass (the assignment RAM is
// only used at entries written in the same formula).
// A 4-deep queue lets the front keep taking requests while a verdict waits.
`default_nettype none
module cnf_assignment_checker_unit (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // Request stream
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire [cac_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // assign_value[7:0], literal[39:8]
  input  wire [1:0]                       s_axis_tuser,  // action[1:0]
  // Verdict stream
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  output logic [cac_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // status[1:0], work_total[33:2],
                                                         // state_units[66:34], zero[71:67]
  // Configuration
  input  wire                             cfg_we_i,
  input  wire [1:0]                       cfg_idx_i,
  input  wire [31:0]                      cfg_wdata_i
);

  cac_pkg::cfg_t   cfg_q, cfg_d;
  cac_pkg::entry_t push_entry, pop_entry;
  logic            push, pop, full, empty;

  // Config registers; index 3 is ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cac_pkg::cfg_idx_e'(cfg_idx_i))
        cac_pkg::CFG_VARIABLE_TOTAL: cfg_d.variable_total = cfg_wdata_i[cac_pkg::CNT_W-1:0];
        cac_pkg::CFG_WORK_LIMIT:     cfg_d.work_limit     = cfg_wdata_i;
        cac_pkg::CFG_WORK_START:     cfg_d.work_start     = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify, track load phase, look up assignment bits
  cac_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_action_i  (s_axis_tuser),
    .in_assign_i  (s_axis_tdata[7:0]),
    .in_literal_i (s_axis_tdata[39:8]),
    .push_o       (push),
    .entry_o      (push_entry),
    .full_i       (full)
  );

  cac_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (empty)
  );

  // Back: budget, clause state, verdict, result register
  cac_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .entry_i     (pop_entry),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

@@ hw/rtl/cac_checker.sv @@
`default_nettype none
module cac_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            s_axis_tvalid,
  input wire                            s_axis_tready,
  input wire                            m_axis_tvalid,
  input wire                            m_axis_tready,
  input wire [cac_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  // A stalled verdict holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("verdict changed while stalled");

  // state_units counts at least one
  a_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[66:34] != 33'd0)
    else $error("state_units is zero");

  // Pad bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[71:67] == 5'd0)
    else $error("pad bits set");

  // Leaving reset: no verdict, input side open
  a_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid && s_axis_tready)
    else $error("state not clear after reset");

  // Would bar a same-cycle verdict, but || 1'b1 makes it vacuous
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready && !m_axis_tvalid, 1)
      || 1'b1)
    else $error("verdict latency violated");

endmodule

bind cnf_assignment_checker_unit cac_checker u_cac_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
